### sv/lbvs_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the linear blend skinning block.
// No dependencies; used by every other file of the block but lbvs_div.
package lbvs_pkg;

    localparam logic ACT_PALETTE   = 1'b0;
    localparam logic ACT_INFLUENCE = 1'b1;

    localparam logic [1:0] CFG_BONES = 2'd0;
    localparam logic [1:0] CFG_NORM  = 2'd1;
    localparam logic [1:0] CFG_NRM   = 2'd2;

    localparam logic [1:0] ST_SKINNED  = 2'd0;
    localparam logic [1:0] ST_PASS     = 2'd1;
    localparam logic [1:0] ST_BAD_BONE = 2'd2;

    localparam int S_DATA_W = 256;
    localparam int M_DATA_W = 200;
    localparam int CFG_W    = 9;

    typedef struct packed {
        logic       take;
        logic       issue;
        logic [1:0] col;
        logic [1:0] row;
        logic       decide;
        logic       div_start;
        logic       div_nrm;
        logic [1:0] comp;
        logic       store_pos;
        logic       store_nrm;
        logic       nrm_load;
        logic       nrm_shift;
        logic       sq_step;
        logic       sqrt_step;
        logic [4:0] cnt;
        logic       clear;
    } lbvs_cmd_t;

    typedef struct packed {
        logic hit;
        logic pipe_idle;
        logic wt_zero;
        logic err;
        logic norm_w;
        logic nrm_en;
        logic div_done;
        logic m_zero;
        logic m_ok;
    } lbvs_sts_t;

endpackage

### sv/lbvs_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle, with rounding to
// nearest (halves away from zero) and 32-bit saturation. No package use.
module lbvs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic        [31:0] den,
    output logic               done,
    output logic signed [31:0] q
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic [63:0] abs_num;
    logic [32:0] rem_sh;
    logic [32:0] rem_diff;
    logic        ge;
    logic        hi;

    always_comb
    begin
        abs_num  = num[63] ? 64'(-num) : 64'(num);
        rem_sh   = {rem_reg, dvd_reg[63]};
        rem_diff = rem_sh - {1'b0, den_reg};
        ge       = rem_sh >= {1'b0, den_reg};
        hi       = |dvd_reg[63:31];
        if (neg_reg)
            q = hi ? 32'sh8000_0000 : -$signed(dvd_reg[31:0]);
        else
            q = hi ? 32'sh7FFF_FFFF : $signed(dvd_reg[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[63];
            den_reg <= den;
            rem_reg <= '0;
            dvd_reg <= abs_num + {33'd0, den[31:1]};
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_diff[31:0] : rem_sh[31:0];
            dvd_reg <= {dvd_reg[62:0], ge};
        end
    end

    assign done = done_reg;

endmodule

### sv/lbvs_dp.sv
`timescale 1ns / 1ps
// Datapath: bone palette memory, transform and weighting pipeline,
// accumulators, normal rescale and square root. Uses lbvs_pkg, lbvs_div.
module lbvs_dp #(
    parameter int MAX_BONES    = 256,
    parameter int MATRIX_WORDS = 12,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lbvs_pkg::lbvs_cmd_t                 cmd,
    input  logic [lbvs_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                s_action,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [lbvs_pkg::CFG_W-1:0]          cfg_wdata,
    output logic [lbvs_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [1:0]                          m_tuser,
    output lbvs_pkg::lbvs_sts_t                 sts
);

    localparam int DEPTH = MAX_BONES * MATRIX_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CS    = MATRIX_WORDS / 4;
    localparam int SUM_W = 66 - FRAC_BITS;
    localparam int WEIGHT_FRAC = 15;
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_HI  = 65'sh0_7FFF_FFFF_FFFF_FFFF;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (x < -64'sh0000_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [47:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > SUM_HI)
            return ACC_MAX;
        else if (s < -SUM_HI)
            return -ACC_MAX;
        else
            return s[63:0];
    endfunction

    // input fields
    logic        [7:0]  in_bone;
    logic        [3:0]  in_elem;
    logic signed [31:0] in_word;
    logic signed [31:0] in_vtx [6];
    logic        [15:0] in_weight;

    always_comb
    begin
        in_bone   = s_tdata[7:0];
        in_elem   = s_tdata[11:8];
        in_word   = $signed(s_tdata[43:12]);
        for (int i = 0; i < 6; i++)
            in_vtx[i] = $signed(s_tdata[44 + 32 * i +: 32]);
        in_weight = s_tdata[251:236];
    end

    // configuration
    logic [8:0] bones_reg;
    logic       normw_reg;
    logic       nrm_en_reg;

    // vertex state
    logic signed [63:0] accp_reg [3];
    logic signed [63:0] accn_reg [3];
    logic        [23:0] wt_reg;
    logic               inside_reg;
    logic               err_reg;
    logic        [7:0]  bad_reg;
    logic signed [31:0] hv_reg [6];
    logic        [7:0]  bone_reg;
    logic        [15:0] w_reg;

    // palette memory
    logic signed [31:0] pal_mem [DEPTH];
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               wr_ok;

    // pipeline
    logic               p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic [1:0]         p1_col_reg, p1_row_reg, p2_col_reg, p2_row_reg;
    logic [1:0]         p3_row_reg, p4_row_reg;
    logic signed [31:0] rd_reg, p2_word_reg;
    logic signed [63:0] pprod_reg, nprod_reg, pprod_next, nprod_next;
    logic signed [31:0] mul_p, mul_n;
    logic signed [SUM_W-1:0] psum_reg, nsum_reg, psum_next, nsum_next;
    logic signed [SUM_W-1:0] term_p, term_n;
    logic signed [47:0] pw_reg, nw_reg, pw_next, nw_next;

    // finishing
    logic signed [63:0] nv_reg [3];
    logic        [63:0] m_reg;
    logic        [63:0] sq_reg;
    logic        [63:0] res_reg;
    logic signed [63:0] sq_val;
    logic        [63:0] sbit;
    logic        [63:0] sq_t;
    logic        [63:0] abs_n [3];
    logic        [63:0] m_next;
    logic signed [31:0] op_reg [3];
    logic signed [31:0] on_reg [3];
    logic        [1:0]  ost_reg;
    logic        [7:0]  obad_reg;

    // divider
    logic               div_done;
    logic signed [31:0] div_q;
    logic signed [63:0] div_num;
    logic        [31:0] div_den;

    // accept-time checks
    logic        infl;
    logic        bone_bad;
    logic [24:0] wt_sum;
    logic [23:0] wt_next;

    always_comb
    begin
        infl     = cmd.take && (s_action == lbvs_pkg::ACT_INFLUENCE);
        bone_bad = ({1'b0, in_bone} >= bones_reg) || (32'(in_bone) >= 32'(MAX_BONES));
        wt_sum   = {1'b0, wt_reg} + 25'(in_weight);
        wt_next  = wt_sum[24] ? 24'hFF_FFFF : wt_sum[23:0];
        wr_ok    = cmd.take && (s_action == lbvs_pkg::ACT_PALETTE)
                   && (32'(in_elem) < 32'(MATRIX_WORDS)) && (32'(in_bone) < 32'(MAX_BONES));
        wr_addr  = AW'(32'(in_bone) * 32'(MATRIX_WORDS) + 32'(in_elem));
        rd_addr  = AW'(32'(bone_reg) * 32'(MATRIX_WORDS) + 32'(cmd.col) * 32'(CS)
                       + 32'(cmd.row));
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
            pal_mem[wr_addr] <= in_word;
        if (cmd.issue)
            rd_reg <= pal_mem[rd_addr];
    end

    // transform pipeline arithmetic
    always_comb
    begin
        mul_p = '0;
        mul_n = '0;
        case (p1_col_reg)
            2'd0:
            begin
                mul_p = hv_reg[0];
                mul_n = hv_reg[3];
            end
            2'd1:
            begin
                mul_p = hv_reg[1];
                mul_n = hv_reg[4];
            end
            2'd2:
            begin
                mul_p = hv_reg[2];
                mul_n = hv_reg[5];
            end
            default:
            begin
                mul_p = '0;
                mul_n = '0;
            end
        endcase
        pprod_next = mul_p * rd_reg;
        nprod_next = mul_n * rd_reg;
        if (p2_col_reg == 2'd3)
        begin
            term_p = SUM_W'(p2_word_reg);
            term_n = '0;
        end
        else
        begin
            term_p = SUM_W'(pprod_reg >>> FRAC_BITS);
            term_n = SUM_W'(nprod_reg >>> FRAC_BITS);
        end
        psum_next = ((p2_col_reg == 2'd0) ? '0 : psum_reg) + term_p;
        nsum_next = ((p2_col_reg == 2'd0) ? '0 : nsum_reg) + term_n;
        pw_next   = sat32(64'(psum_reg)) * $signed({1'b0, w_reg});
        nw_next   = sat32(64'(nsum_reg)) * $signed({1'b0, w_reg});
    end

    // normal finishing arithmetic
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            abs_n[i] = accn_reg[i][63] ? 64'(-accn_reg[i]) : 64'(accn_reg[i]);
        m_next = abs_n[0];
        if (abs_n[1] > m_next)
            m_next = abs_n[1];
        if (abs_n[2] > m_next)
            m_next = abs_n[2];
        sq_val = $signed(nv_reg[cmd.comp][31:0]) * $signed(nv_reg[cmd.comp][31:0]);
        sbit   = 64'd1 << {~cmd.cnt, 1'b0};
        sq_t   = res_reg + sbit;
        div_num = cmd.div_nrm ? (nv_reg[cmd.comp] <<< FRAC_BITS) : accp_reg[cmd.comp];
        div_den = cmd.div_nrm ? res_reg[31:0] : {8'd0, wt_reg};
    end

    lbvs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .q     (div_q)
    );

    // control and vertex state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bones_reg  <= 9'd256;
            normw_reg  <= 1'b1;
            nrm_en_reg <= 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                accp_reg[i] <= '0;
                accn_reg[i] <= '0;
            end
            wt_reg     <= '0;
            inside_reg <= 1'b0;
            err_reg    <= 1'b0;
            bad_reg    <= '0;
            p1_v_reg   <= 1'b0;
            p2_v_reg   <= 1'b0;
            p3_v_reg   <= 1'b0;
            p4_v_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lbvs_pkg::CFG_BONES: bones_reg  <= cfg_wdata;
                    lbvs_pkg::CFG_NORM:  normw_reg  <= cfg_wdata[0];
                    lbvs_pkg::CFG_NRM:   nrm_en_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            p1_v_reg <= cmd.issue;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg && (p2_col_reg == 2'd3);
            p4_v_reg <= p3_v_reg;
            if (p4_v_reg)
            begin
                accp_reg[p4_row_reg] <= sat_add(accp_reg[p4_row_reg], pw_reg);
                if (nrm_en_reg)
                    accn_reg[p4_row_reg] <= sat_add(accn_reg[p4_row_reg], nw_reg);
            end
            if (infl)
            begin
                inside_reg <= 1'b1;
                if (in_weight != 16'd0)
                begin
                    wt_reg <= wt_next;
                    if (!err_reg && bone_bad)
                    begin
                        err_reg <= 1'b1;
                        bad_reg <= in_bone;
                    end
                end
            end
            if (cmd.clear)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    accp_reg[i] <= '0;
                    accn_reg[i] <= '0;
                end
                wt_reg     <= '0;
                inside_reg <= 1'b0;
                err_reg    <= 1'b0;
                bad_reg    <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (infl && !inside_reg)
        begin
            for (int i = 0; i < 6; i++)
                hv_reg[i] <= in_vtx[i];
        end
        if (infl)
        begin
            bone_reg <= in_bone;
            w_reg    <= in_weight;
        end
        if (cmd.issue)
        begin
            p1_col_reg <= cmd.col;
            p1_row_reg <= cmd.row;
        end
        p2_col_reg  <= p1_col_reg;
        p2_row_reg  <= p1_row_reg;
        p2_word_reg <= rd_reg;
        pprod_reg   <= pprod_next;
        nprod_reg   <= nprod_next;
        if (p2_v_reg)
        begin
            psum_reg <= psum_next;
            nsum_reg <= nsum_next;
        end
        p3_row_reg <= p2_row_reg;
        p4_row_reg <= p3_row_reg;
        pw_reg     <= pw_next;
        nw_reg     <= nw_next;

        if (cmd.decide)
        begin
            ost_reg  <= (wt_reg == 24'd0) ? lbvs_pkg::ST_PASS :
                        err_reg ? lbvs_pkg::ST_BAD_BONE : lbvs_pkg::ST_SKINNED;
            obad_reg <= ((wt_reg != 24'd0) && err_reg) ? bad_reg : 8'd0;
            for (int i = 0; i < 3; i++)
            begin
                if (wt_reg == 24'd0)
                    op_reg[i] <= hv_reg[i];
                else if (err_reg || normw_reg)
                    op_reg[i] <= '0;
                else
                    op_reg[i] <= sat32(accp_reg[i] >>> WEIGHT_FRAC);
                on_reg[i] <= ((wt_reg == 24'd0) && nrm_en_reg) ? hv_reg[3 + i] : 32'sd0;
            end
        end
        if (cmd.store_pos)
            op_reg[cmd.comp] <= div_q;
        if (cmd.store_nrm)
            on_reg[cmd.comp] <= div_q;

        if (cmd.nrm_load)
        begin
            for (int i = 0; i < 3; i++)
                nv_reg[i] <= accn_reg[i];
            m_reg <= m_next;
        end
        else if (cmd.nrm_shift)
        begin
            if (|m_reg[63:30])
            begin
                m_reg <= m_reg >> 1;
                for (int i = 0; i < 3; i++)
                    nv_reg[i] <= nv_reg[i] >>> 1;
            end
            else
            begin
                m_reg <= m_reg << 1;
                for (int i = 0; i < 3; i++)
                    nv_reg[i] <= nv_reg[i] <<< 1;
            end
        end
        if (cmd.sq_step)
        begin
            if (cmd.comp == 2'd0)
            begin
                sq_reg  <= 64'(sq_val);
                res_reg <= '0;
            end
            else
                sq_reg <= sq_reg + 64'(sq_val);
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_reg >= sq_t)
            begin
                sq_reg  <= sq_reg - sq_t;
                res_reg <= (res_reg >> 1) + sbit;
            end
            else
                res_reg <= res_reg >> 1;
        end
    end

    always_comb
    begin
        sts.hit       = (s_action == lbvs_pkg::ACT_INFLUENCE) && (in_weight != 16'd0)
                        && !err_reg && !bone_bad;
        sts.pipe_idle = !(p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg);
        sts.wt_zero   = wt_reg == 24'd0;
        sts.err       = err_reg;
        sts.norm_w    = normw_reg;
        sts.nrm_en    = nrm_en_reg;
        sts.div_done  = div_done;
        sts.m_zero    = m_reg == 64'd0;
        sts.m_ok      = (m_reg[63:30] == 34'd0) && m_reg[29];
    end

    assign m_tdata = {obad_reg, on_reg[2], on_reg[1], on_reg[0],
                      op_reg[2], op_reg[1], op_reg[0]};
    assign m_tuser = ost_reg;

endmodule

### sv/lbvs_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: palette fetch, drain, vertex finishing steps
// and result handoff. Uses lbvs_pkg command and status types.
module lbvs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_action,
    input  logic                s_last,
    input  logic                m_tready,
    input  lbvs_pkg::lbvs_sts_t sts,
    output logic                s_tready,
    output logic                m_tvalid,
    output lbvs_pkg::lbvs_cmd_t cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_FETCH     = 4'd1;
    localparam logic [3:0] S_DRAIN     = 4'd2;
    localparam logic [3:0] S_DECIDE    = 4'd3;
    localparam logic [3:0] S_PDIV_GO   = 4'd4;
    localparam logic [3:0] S_PDIV_WAIT = 4'd5;
    localparam logic [3:0] S_NLOAD     = 4'd6;
    localparam logic [3:0] S_NSHIFT    = 4'd7;
    localparam logic [3:0] S_NSQ       = 4'd8;
    localparam logic [3:0] S_NSQRT     = 4'd9;
    localparam logic [3:0] S_NDIV_GO   = 4'd10;
    localparam logic [3:0] S_NDIV_WAIT = 4'd11;
    localparam logic [3:0] S_OUT       = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic       last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        cmd.cnt    = cnt_reg;
        cmd.col    = cnt_reg[1:0];
        cmd.row    = cnt_reg[3:2];
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && (s_action == lbvs_pkg::ACT_INFLUENCE))
                begin
                    last_next = s_last;
                    if (sts.hit)
                    begin
                        cnt_next   = '0;
                        state_next = S_FETCH;
                    end
                    else if (s_last)
                        state_next = S_DECIDE;
                end
            end
            S_FETCH:
            begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd11)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (sts.pipe_idle)
                    state_next = last_reg ? S_DECIDE : S_IDLE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                comp_next  = '0;
                if (sts.wt_zero || sts.err)
                    state_next = S_OUT;
                else if (sts.norm_w)
                    state_next = S_PDIV_GO;
                else if (sts.nrm_en)
                    state_next = S_NLOAD;
                else
                    state_next = S_OUT;
            end
            S_PDIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_PDIV_WAIT;
            end
            S_PDIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.store_pos = 1'b1;
                    if (comp_reg == 2'd2)
                        state_next = sts.nrm_en ? S_NLOAD : S_OUT;
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_PDIV_GO;
                    end
                end
            end
            S_NLOAD:
            begin
                cmd.nrm_load = 1'b1;
                state_next   = S_NSHIFT;
            end
            S_NSHIFT:
            begin
                if (sts.m_zero)
                    state_next = S_OUT;
                else if (sts.m_ok)
                begin
                    comp_next  = '0;
                    state_next = S_NSQ;
                end
                else
                    cmd.nrm_shift = 1'b1;
            end
            S_NSQ:
            begin
                cmd.sq_step = 1'b1;
                if (comp_reg == 2'd2)
                begin
                    cnt_next   = '0;
                    state_next = S_NSQRT;
                end
                else
                    comp_next = comp_reg + 2'd1;
            end
            S_NSQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    comp_next  = '0;
                    state_next = S_NDIV_GO;
                end
            end
            S_NDIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_nrm   = 1'b1;
                state_next    = S_NDIV_WAIT;
            end
            S_NDIV_WAIT:
            begin
                cmd.div_nrm = 1'b1;
                if (sts.div_done)
                begin
                    cmd.store_nrm = 1'b1;
                    if (comp_reg == 2'd2)
                        state_next = S_OUT;
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_NDIV_GO;
                    end
                end
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            last_reg  <= last_next;
        end
    end

endmodule

### sv/linear_blend_vertex_skinning.sv
`timescale 1ns / 1ps
// Top level of the linear blend skinning block: controller and datapath.
// Depends on lbvs_pkg, lbvs_ctrl, lbvs_dp (and lbvs_div below it).
//
// Usage: s_* carries items. tuser is the action (palette word write or
// vertex influence), tlast marks the last influence of a vertex. A
// nonzero-weight influence on a valid bone, with no bad bone seen before
// in the vertex, does twelve palette reads through the single memory read
// port, then a drain of the multiply and accumulate pipeline. Zero-weight
// or bad-bone influences do no palette reads. On the last influence the
// block finishes the vertex: up to three divisions for the position, and
// for the normal a bit-serial rescale, three squares, a 32-step square
// root and three more divisions. One item is in work at a time; s_tready
// stays low from acceptance of an influence until its work is done.
// The result waits in the output register while m_tvalid is high and
// m_tready low; no input is taken then. cfg_* writes a register per
// cycle; the user must write only while idle, the block does not enforce
// it. Reset clears accumulators and restores register defaults; palette
// contents are undefined until written.
module linear_blend_vertex_skinning #(
    parameter int MAX_BONES    = 256,
    parameter int MATRIX_WORDS = 12,
    parameter int FRAC_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // bone, element, matrix_word, pos_x, pos_y, pos_z, nrm_x, nrm_y,
    // nrm_z, weight, zero fill
    input  logic [lbvs_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    // action
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z, bad_bone
    output logic [lbvs_pkg::M_DATA_W-1:0]     m_tdata,
    // status
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [lbvs_pkg::CFG_W-1:0]        cfg_wdata
);

    lbvs_pkg::lbvs_cmd_t cmd;
    lbvs_pkg::lbvs_sts_t sts;

    lbvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser[0]),
        .s_last   (s_tlast),
        .m_tready (m_tready),
        .sts      (sts),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    lbvs_dp #(
        .MAX_BONES    (MAX_BONES),
        .MATRIX_WORDS (MATRIX_WORDS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_action  (s_tuser[0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .sts       (sts)
    );

endmodule

### sv/lbvs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the skinning block, bound to the top level.
// Depends on lbvs_pkg for status codes.
module lbvs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lbvs_pkg::M_DATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == lbvs_pkg::ST_BAD_BONE) |-> m_tdata[191:0] == 192'd0)
        else $error("bad bone result carries data");

    a_bone_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != lbvs_pkg::ST_BAD_BONE) |-> m_tdata[199:192] == 8'd0)
        else $error("bad_bone set without error status");

    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    a_resume: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> s_tready)
        else $error("not ready after result delivered");

endmodule

bind linear_blend_vertex_skinning lbvs_checker u_lbvs_checker (.*);

### verif/linear_blend_vertex_skinning_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for linear_blend_vertex_skinning: a directed table
// then random vertex streams; each result is checked against a local predictor
// or a typed table entry. Depends on lbvs_pkg and the RTL of the block.
module linear_blend_vertex_skinning_tb;

    localparam int  NBONES    = 256;
    localparam int  NWORDS    = 12;
    localparam int  LIMIT     = 1500000;
    localparam int  SETTLE    = 600;
    localparam logic [63:0] ACC_MAX = 64'h7fff_ffff_ffff_ffff;

    localparam logic [1:0] ROW_PAL = 2'd0;
    localparam logic [1:0] ROW_INF = 2'd1;
    localparam logic [1:0] ROW_CFG = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       bone;
        logic [3:0]       elem;
        logic [31:0]      word;
        logic [5:0][31:0] vtx;
        logic [15:0]      weight;
        logic             last;
    } skin_item_t;

    typedef struct packed {
        logic [5:0][31:0] v;
        logic [1:0]       st;
        logic [7:0]       bb;
    } vtx_res_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [lbvs_pkg::S_DATA_W-1:0]  s_tdata;
    logic                           s_tlast;
    logic [0:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [lbvs_pkg::M_DATA_W-1:0]  m_tdata;
    logic [1:0]                     m_tuser;
    logic                           cfg_we;
    logic [1:0]                     cfg_index;
    logic [lbvs_pkg::CFG_W-1:0]     cfg_wdata;

    linear_blend_vertex_skinning uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    int          pal [NBONES*NWORDS];
    bit          pal_valid [NBONES];
    longint      pacc [3];
    longint      nacc [3];
    int unsigned wsum;
    longint      held [6];
    bit          in_vtx;
    bit          err_seen;
    logic [7:0]  err_bone;
    int unsigned bones_lim;
    bit          norm_on;
    bit          nrm_on;

    vtx_res_t    expected_vertices [$];
    skin_item_t  dir_rows [$];
    vtx_res_t    dir_exp [$];
    bit          dir_has_exp [$];

    int          fails;
    int          cycles;
    int          n_items;
    int          n_results;
    int          n_bad;
    int          n_pass;
    int          burst_left;
    bit          gaps_on;
    int          rdy_mode;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver stall pattern, mode redrawn at random among four
    always @(negedge clk)
    begin
        if (cycles % 64 == 0)
            rdy_mode = $urandom_range(0, 3);
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= ((cycles / 7) % 2 == 0);
        endcase
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint sat_acc(longint a, longint b);
        if (b > 0 && a > longint'(ACC_MAX) - b)
            return longint'(ACC_MAX);
        if (b < 0 && a < -longint'(ACC_MAX) - b)
            return -longint'(ACC_MAX);
        return a + b;
    endfunction

    function automatic longint unsigned mag(longint x);
        longint unsigned r;
        r = (x < 0) ? -x : x;
        return r;
    endfunction

    function automatic longint round_div_sat(longint num, longint unsigned den);
        longint unsigned q;
        q = (mag(num) + den / 2) / den;
        if (num < 0)
            return (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'h7fff_ffff) ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void unit_vec(output longint o [3]);
        longint unsigned m;
        longint unsigned sq;
        longint unsigned len;
        longint          v [3];
        int              dn;
        int              up;
        m = 0;
        sq = 0;
        dn = 0;
        up = 0;
        for (int i = 0; i < 3; i++)
            if (mag(nacc[i]) > m)
                m = mag(nacc[i]);
        if (m == 0)
        begin
            for (int i = 0; i < 3; i++)
                o[i] = 0;
            return;
        end
        while ((m >> dn) >= 64'd1 << 30)
            dn++;
        while ((m << up) < 64'd1 << 29)
            up++;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = (nacc[i] >>> dn) <<< up;
            sq = sq + longint'(v[i] * v[i]);
        end
        len = floor_sqrt(sq);
        for (int i = 0; i < 3; i++)
            o[i] = round_div_sat(v[i] <<< 16, len);
    endfunction

    function automatic void clear_vtx();
        for (int i = 0; i < 3; i++)
        begin
            pacc[i] = 0;
            nacc[i] = 0;
        end
        for (int i = 0; i < 6; i++)
            held[i] = 0;
        wsum = 0;
        in_vtx = 0;
        err_seen = 0;
        err_bone = 0;
    endfunction

    function automatic bit skin_predict(input skin_item_t it, output vtx_res_t r);
        longint t;
        longint n;
        longint o [3];
        int     base;
        r = '0;
        if (it.kind == ROW_PAL)
        begin
            if (it.elem < NWORDS)
                pal[it.bone*NWORDS + it.elem] = it.word;
            return 0;
        end
        if (!in_vtx)
        begin
            for (int i = 0; i < 6; i++)
                held[i] = longint'(signed'(it.vtx[i]));
            in_vtx = 1;
        end
        if (it.weight != 0)
        begin
            wsum = wsum + it.weight;
            if (wsum > 24'hffffff)
                wsum = 24'hffffff;
            if (!err_seen && it.bone >= bones_lim)
            begin
                err_seen = 1;
                err_bone = it.bone;
            end
            if (!err_seen)
            begin
                base = it.bone * NWORDS;
                for (int rr = 0; rr < 3; rr++)
                begin
                    t = pal[base + 9 + rr];
                    n = 0;
                    for (int c = 0; c < 3; c++)
                    begin
                        t += (held[c] * longint'(pal[base + c*3 + rr])) >>> 16;
                        n += (held[3+c] * longint'(pal[base + c*3 + rr])) >>> 16;
                    end
                    pacc[rr] = sat_acc(pacc[rr], sat32(t) * longint'(it.weight));
                    if (nrm_on)
                        nacc[rr] = sat_acc(nacc[rr], sat32(n) * longint'(it.weight));
                end
            end
        end
        if (!it.last)
            return 0;
        if (wsum == 0)
        begin
            r.st = lbvs_pkg::ST_PASS;
            for (int i = 0; i < 3; i++)
            begin
                r.v[i] = 32'(held[i]);
                r.v[3+i] = nrm_on ? 32'(held[3+i]) : 32'd0;
            end
        end
        else if (err_seen)
        begin
            r.st = lbvs_pkg::ST_BAD_BONE;
            r.bb = err_bone;
        end
        else
        begin
            r.st = lbvs_pkg::ST_SKINNED;
            for (int i = 0; i < 3; i++)
                r.v[i] = norm_on ? 32'(round_div_sat(pacc[i], wsum))
                                 : 32'(sat32(pacc[i] >>> 15));
            if (nrm_on)
            begin
                unit_vec(o);
                for (int i = 0; i < 3; i++)
                    r.v[3+i] = 32'(o[i]);
            end
        end
        clear_vtx();
        return 1;
    endfunction

    always @(posedge clk)
    begin
        vtx_res_t e;
        vtx_res_t a;
        if (m_tvalid && m_tready)
        begin
            a.v  = m_tdata[191:0];
            a.bb = m_tdata[199:192];
            a.st = m_tuser;
            n_results++;
            if (expected_vertices.size() == 0)
            begin
                $display("%0t unexpected result %h status %0d", $time, a.v, a.st);
                fails++;
            end
            else
            begin
                e = expected_vertices.pop_front();
                for (int i = 0; i < 6; i++)
                    if (e.v[i] !== a.v[i])
                    begin
                        $display("%0t field %0d expected %h actual %h",
                                 $time, i, e.v[i], a.v[i]);
                        fails++;
                    end
                if (e.st !== a.st)
                begin
                    $display("%0t status expected %0d actual %0d", $time, e.st, a.st);
                    fails++;
                end
                if (e.bb !== a.bb)
                begin
                    $display("%0t bad_bone expected %0d actual %0d", $time, e.bb, a.bb);
                    fails++;
                end
            end
        end
    end

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [lbvs_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == lbvs_pkg::CFG_BONES)
            bones_lim = val;
        else if (idx == lbvs_pkg::CFG_NORM)
            norm_on = val[0];
        else if (idx == lbvs_pkg::CFG_NRM)
            nrm_on = val[0];
    endtask

    task automatic set_regs(input logic [lbvs_pkg::CFG_W-1:0] bones, input bit nw,
                            input bit ne);
        write_reg(lbvs_pkg::CFG_BONES, bones);
        write_reg(lbvs_pkg::CFG_NORM, {8'd0, nw});
        write_reg(lbvs_pkg::CFG_NRM, {8'd0, ne});
    endtask

    // drive one item; typed expectation replaces the predicted one when given
    task automatic send(input skin_item_t it, input bit typed, input vtx_res_t te);
        vtx_res_t r;
        int       gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= (it.kind == ROW_PAL) ? lbvs_pkg::ACT_PALETTE : lbvs_pkg::ACT_INFLUENCE;
        s_tlast  <= it.last;
        s_tdata  <= {4'b0, it.weight, it.vtx, it.word, it.elem, it.bone};
        do
            @(posedge clk);
        while (!s_tready);
        n_items++;
        if (skin_predict(it, r))
        begin
            if (typed)
                r = te;
            if (r.st == lbvs_pkg::ST_BAD_BONE)
                n_bad++;
            else if (r.st == lbvs_pkg::ST_PASS)
                n_pass++;
            expected_vertices.insert(expected_vertices.size(), r);
        end
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic skin_item_t mk(logic [1:0] k, logic [7:0] b, logic [3:0] e,
                                      logic [31:0] w, logic [15:0] wt, logic l);
        skin_item_t it;
        it = '0;
        it.kind = k;
        it.bone = b;
        it.elem = e;
        it.word = w;
        it.weight = wt;
        it.last = l;
        return it;
    endfunction

    task automatic row(input skin_item_t it, input bit typed, input vtx_res_t te);
        dir_rows.insert(dir_rows.size(), it);
        dir_has_exp.insert(dir_has_exp.size(), typed);
        dir_exp.insert(dir_exp.size(), te);
    endtask

    task automatic load_bone(input int b);
        skin_item_t it;
        vtx_res_t   none;
        none = '0;
        for (int e = 0; e < NWORDS; e++)
        begin
            it = mk(ROW_PAL, b, e, rnd_val(), $urandom, $urandom_range(0, 1));
            it.vtx = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            if (b == 0 || b == 1)
                it.word = (e % 4 == 0) ? 32'h0001_0000 : 32'h0;
            if (b == 1 && e >= 9)
                it.word = (e - 8) << 16;
            send(it, 0, none);
        end
        pal_valid[b] = 1;
    endtask

    task automatic random_vertex();
        skin_item_t it;
        vtx_res_t   none;
        int         k;
        none = '0;
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // palette rewrite or ignored write
                it = mk(ROW_PAL, $urandom, $urandom_range(0, 15), rnd_val(), $urandom, 0);
                if (it.elem < NWORDS && !pal_valid[it.bone])
                    it.elem = NWORDS + it.elem[1:0];
                send(it, 0, none);
            end
            it = mk(ROW_INF, 0, $urandom, $urandom, 0, i == k - 1);
            it.bone = $urandom_range(0, 7) + (($urandom_range(0, 1) == 1) ? 248 : 0);
            if ($urandom_range(0, 5) == 0)
                it.bone = $urandom;
            case ($urandom_range(0, 9))
                0: it.weight = 0;
                1: it.weight = 16'hffff;
                default: it.weight = $urandom_range(1, 16'hffff);
            endcase
            if (it.weight != 0 && !err_seen && it.bone < bones_lim && !pal_valid[it.bone])
                it.bone = it.bone[2:0];
            for (int j = 0; j < 6; j++)
                it.vtx[j] = rnd_val();
            send(it, 0, none);
        end
    endtask

    initial
    begin
        skin_item_t it;
        vtx_res_t   te;
        vtx_res_t   none;
        none = '0;
        clk = 1'b0;
        fails = 0;
        cycles = 0;
        n_items = 0;
        n_results = 0;
        n_bad = 0;
        n_pass = 0;
        burst_left = 0;
        gaps_on = 1;
        rdy_mode = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        s_tuser = lbvs_pkg::ACT_PALETTE;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lbvs_pkg::CFG_BONES;
        cfg_wdata = '0;
        for (int i = 0; i < NBONES*NWORDS; i++)
            pal[i] = 0;
        for (int i = 0; i < NBONES; i++)
            pal_valid[i] = 0;
        clear_vtx();
        bones_lim = 256;
        norm_on = 1;
        nrm_on = 1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int b = 0; b < 8; b++)
            load_bone(b);
        for (int b = 248; b < 256; b++)
            load_bone(b);

        // directed table
        it = mk(ROW_INF, 3, 0, 0, 0, 1);
        it.vtx = {32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff};
        te = '0;
        te.st = lbvs_pkg::ST_PASS;
        te.v = it.vtx;
        row(it, 1, te);
        it = mk(ROW_INF, 0, 0, 0, 16'h8000, 1);
        it.vtx = {32'h0001_0000, 32'h0, 32'h0, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000};
        te = '0;
        te.st = lbvs_pkg::ST_SKINNED;
        te.v = it.vtx;
        row(it, 1, te);
        it = mk(ROW_INF, 0, 0, 0, 16'h4000, 1);
        te = '0;
        te.st = lbvs_pkg::ST_SKINNED;
        row(it, 1, te);
        it = mk(ROW_INF, 0, 0, 0, 16'h4000, 0);
        it.vtx = {32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000};
        row(it, 0, none);
        it = mk(ROW_INF, 1, 0, 0, 16'h4000, 1);
        it.vtx = {6{32'h7fff_ffff}};
        row(it, 0, none);
        it = mk(ROW_INF, 255, 0, 0, 16'hffff, 1);
        it.vtx = {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        row(it, 0, none);
        it = mk(ROW_INF, 200, 0, 0, 0, 0);
        it.vtx = {32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000};
        row(it, 0, none);
        it = mk(ROW_INF, 2, 0, 0, 16'h0001, 0);
        row(it, 0, none);
        it = mk(ROW_INF, 250, 0, 0, 16'h7fff, 1);
        row(it, 0, none);
        row(mk(ROW_PAL, 255, 15, 32'hffff_ffff, 16'hffff, 1), 0, none);
        row(mk(ROW_PAL, 7, 12, 32'h1234_5678, 16'h0, 0), 0, none);
        row(mk(ROW_CFG, 0, lbvs_pkg::CFG_BONES, 4, 0, 0), 0, none);
        it = mk(ROW_INF, 5, 0, 0, 16'h0001, 1);
        te = '0;
        te.st = lbvs_pkg::ST_BAD_BONE;
        te.bb = 5;
        row(it, 1, te);
        row(mk(ROW_INF, 200, 0, 0, 0, 0), 0, none);
        row(mk(ROW_INF, 1, 0, 0, 16'h0100, 0), 0, none);
        row(mk(ROW_INF, 9, 0, 0, 16'h0064, 0), 0, none);
        it = mk(ROW_INF, 6, 0, 0, 16'h0005, 1);
        te.bb = 9;
        row(it, 1, te);
        row(mk(ROW_CFG, 0, lbvs_pkg::CFG_NORM, 0, 0, 0), 0, none);
        row(mk(ROW_CFG, 0, lbvs_pkg::CFG_NRM, 0, 0, 0), 0, none);
        it = mk(ROW_INF, 1, 0, 0, 16'h8000, 1);
        it.vtx = {32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'hffff_0000, 32'h0001_0000};
        row(it, 0, none);
        it = mk(ROW_INF, 1, 0, 0, 0, 1);
        it.vtx = {32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6};
        te = '0;
        te.st = lbvs_pkg::ST_PASS;
        te.v = {96'h0, 32'h4, 32'h5, 32'h6};
        row(it, 1, te);
        row(mk(ROW_CFG, 0, lbvs_pkg::CFG_BONES, 256, 0, 0), 0, none);
        row(mk(ROW_CFG, 0, lbvs_pkg::CFG_NORM, 1, 0, 0), 0, none);
        row(mk(ROW_CFG, 0, lbvs_pkg::CFG_NRM, 1, 0, 0), 0, none);

        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(dir_rows[i].elem[1:0], dir_rows[i].word[lbvs_pkg::CFG_W-1:0]);
            end
            else
                send(dir_rows[i], dir_has_exp[i], dir_exp[i]);
        end

        // random phases across register settings
        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                0: set_regs(9'd256, 1'b1, 1'b1);
                1: set_regs(9'd0, 1'b1, 1'b0);
                2: set_regs(9'd9, 1'b0, 1'b0);
                3: set_regs(9'd252, 1'b0, 1'b1);
                default: set_regs(9'd256, 1'b1, 1'b1);
            endcase
            gaps_on = (ph != 2);
            repeat (14) random_vertex();
        end

        settle();
        $display("covered %0d items, %0d results (%0d invalid bone, %0d passthrough)",
                 n_items, n_results, n_bad, n_pass);
        $display("register settings swept over bone limits 0 to 256, normalization and normals");
        if (fails == 0 && expected_vertices.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
